### hdl/c_subset_lexer_unit_defines.svh
// ----------------------------------------------------------------------------
// c_subset_lexer_unit_defines
// Assertion macros shared by the lexer RTL files.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_UNIT_DEFINES_SVH
`define C_SUBSET_LEXER_UNIT_DEFINES_SVH

// The condition holds at every rising clock edge outside reset.
`define CSL_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CSL_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CSL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Types, codes and character tables of the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int LENGTH_BITS_DEFAULT   = 8;

    // Result field widths.
    localparam int KIND_BITS   = 3;
    localparam int SUB_BITS    = 3;
    localparam int START_BITS  = 16;
    localparam int TLEN_BITS   = 8;
    localparam int ERR_BITS    = 2;

    // Stream widths.
    localparam int S_TDATA_BITS = 8;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = 32;
    localparam int M_TUSER_BITS = KIND_BITS + SUB_BITS;
    localparam int M_PAD_BITS   = M_TDATA_BITS - START_BITS - TLEN_BITS - ERR_BITS;

    // Output queue.
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCOUNT_BITS = $clog2(QDEPTH + 1);

    localparam logic [TLEN_BITS-1:0] TOKEN_LEN_MAX = '1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_STR
    } lex_mode_t;

    localparam logic [KIND_BITS-1:0] KIND_KEYWORD  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_LITERAL  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_OPERATOR = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_DELIM    = 3'd4;

    localparam logic [SUB_BITS-1:0] SUB_NONE   = 3'd0;
    localparam logic [SUB_BITS-1:0] SUB_INT    = 3'd0;
    localparam logic [SUB_BITS-1:0] SUB_FLOAT  = 3'd1;
    localparam logic [SUB_BITS-1:0] SUB_STRING = 3'd2;

    localparam logic [ERR_BITS-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_SECOND_DOT = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_OPEN_STR   = 2'd2;

    // Keywords, right aligned, one byte per character.
    localparam int PREFIX_CHARS = 6;
    localparam int PREFIX_BITS  = 8 * PREFIX_CHARS;
    localparam int NUM_KW       = 6;

    localparam logic [PREFIX_BITS-1:0] KW_TEXT [NUM_KW] = '{
        48'h0000_6C6F_6E67,   // long
        48'h0062_7265_616B,   // break
        48'h0000_0000_646F,   // do
        48'h0077_6869_6C65,   // while
        48'h0066_6C6F_6174,   // float
        48'h7072_696E_7466    // printf
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd5, 3'd2, 3'd5, 3'd5, 3'd6};

    localparam int NUM_SINGLE = 6;
    localparam logic [7:0] OP_CHARS  [NUM_SINGLE] = '{8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3E};
    localparam logic [7:0] DEL_CHARS [NUM_SINGLE] = '{8'h29, 8'h28, 8'h2C, 8'h3B, 8'h7B, 8'h7D};

    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_QUOTE      = 8'h22;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [SUB_BITS-1:0]   subtype;
        logic [START_BITS-1:0] start;
        logic [TLEN_BITS-1:0]  length;
        logic [ERR_BITS-1:0]   err;
    } token_t;

    // Up to two tokens from one character; tok0 comes first.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_out_t;

endpackage

`default_nettype wire

### hdl/c_subset_lexer_unit.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_unit
// Streaming tokenizer for a small C subset.
//
// Characters arrive one per beat on the s_ channel; s_tuser[0] marks the end
// of a text, which flushes any pending token and restarts position counting.
// Tokens leave on the m_ channel, one per beat, with m_tlast on the final
// token caused by an input beat. A character gives zero, one or two tokens.
// Tokens are written into a registered output queue and leave from its head.
// Throughput: one character per cycle while the receiver keeps up; a
// character giving two tokens needs two output beats, and the four-entry
// output queue absorbs these until it holds more than two tokens, when
// s_tready drops. When the receiver stalls, queued tokens hold and the input
// keeps being taken until the queue is that full.
// Reset (aresetn low, synchronous) empties the queue and returns the lexer
// to idle at position zero with the error lock clear.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer_unit #(
    parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEFAULT,
    parameter int LENGTH_BITS   = csl_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [csl_pkg::S_TDATA_BITS-1:0] s_tdata,   // char_code
    input  wire logic [csl_pkg::S_TUSER_BITS-1:0] s_tuser,   // end_of_text
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // start_position [15:0], token_length [23:16], error_code [25:24], zeros
    output logic [csl_pkg::M_TDATA_BITS-1:0]      m_tdata,
    // token_kind [2:0], token_subtype [5:3]
    output logic [csl_pkg::M_TUSER_BITS-1:0]      m_tuser,
    output logic                                  m_tlast
);
    import csl_pkg::*;

    `include "c_subset_lexer_unit_defines.svh"

    scan_out_t              scan_out;
    logic                   take, pop;
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_BITS-1:0] q_count_reg, q_count_next;
    logic [1:0]             push_n;
    token_t                 q_tok_reg  [QDEPTH];
    logic                   q_last_reg [QDEPTH];
    token_t                 head;

    assign s_tready = (q_count_reg <= QCOUNT_BITS'(QDEPTH - 2));
    assign take     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    csl_scan #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .char_code   (s_tdata[7:0]),
        .end_of_text (s_tuser[0]),
        .scan_out    (scan_out)
    );

    always_comb begin
        push_n       = take ? scan_out.count : 2'd0;
        wr_ptr_next  = wr_ptr_reg + QPTR_BITS'(push_n);
        rd_ptr_next  = rd_ptr_reg + QPTR_BITS'(pop);
        q_count_next = q_count_reg + QCOUNT_BITS'(push_n) - QCOUNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    // Queue payload; the last flag goes on the final token of the beat.
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_tok_reg[wr_ptr_reg]  <= scan_out.tok0;
            q_last_reg[wr_ptr_reg] <= (push_n == 2'd1);
        end
        if (push_n == 2'd2) begin
            q_tok_reg[wr_ptr_reg + QPTR_BITS'(1)]  <= scan_out.tok1;
            q_last_reg[wr_ptr_reg + QPTR_BITS'(1)] <= 1'b1;
        end
    end

    assign head     = q_tok_reg[rd_ptr_reg];
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = {M_PAD_BITS'(0), head.err, head.length, head.start};
    assign m_tuser  = {head.subtype, head.kind};
    assign m_tlast  = q_last_reg[rd_ptr_reg];

    `CSL_ASSERT_ALWAYS(a_q_bound, aclk, aresetn, q_count_reg <= QCOUNT_BITS'(QDEPTH), "output queue overflow")
    `CSL_ASSERT_NEXT(a_push_shows, aclk, aresetn, take && (scan_out.count != 2'd0), m_tvalid, "queued token not offered")
    `CSL_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && !take, q_count_reg == $past(q_count_reg) - QCOUNT_BITS'(1), "queue count lost a beat")

endmodule

`default_nettype wire

### hdl/csl_scan.sv
// ----------------------------------------------------------------------------
// csl_scan
// Lexer state registers and the per-character scanning logic.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_scan #(
    parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEFAULT,
    parameter int LENGTH_BITS   = csl_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               take,
    input  wire logic [7:0]         char_code,
    input  wire logic               end_of_text,
    output csl_pkg::scan_out_t      scan_out
);
    import csl_pkg::*;

    `include "c_subset_lexer_unit_defines.svh"

    lex_mode_t                mode_reg,   mode_next;
    logic [PREFIX_BITS-1:0]   prefix_reg, prefix_next;
    logic [LENGTH_BITS-1:0]   len_reg,    len_next;
    logic                     dot_reg,    dot_next;
    logic [POSITION_BITS-1:0] start_reg,  start_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic                     lock_reg,   lock_next;

    logic                   is_digit, is_alpha, is_ident;
    logic                   op_hit, del_hit;
    logic [SUB_BITS-1:0]    op_idx, del_idx;
    logic                   kw_hit;
    logic [SUB_BITS-1:0]    kw_idx;
    logic [LENGTH_BITS-1:0] len_grow;
    logic [START_BITS-1:0]  start16, pos16;
    token_t                 word_tok, num_tok;
    token_t                 flush_tok, idle_tok;
    logic                   flush_valid, idle_valid, run_idle;

    function automatic logic [TLEN_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] v);
        logic [TLEN_BITS-1:0] r;
        if (16'(v) > 16'(TOKEN_LEN_MAX)) begin
            r = TOKEN_LEN_MAX;
        end else begin
            r = TLEN_BITS'(v);
        end
        return r;
    endfunction

    function automatic token_t make_tok(input logic [KIND_BITS-1:0] kind,
                                        input logic [SUB_BITS-1:0] sub,
                                        input logic [START_BITS-1:0] start,
                                        input logic [TLEN_BITS-1:0] len,
                                        input logic [ERR_BITS-1:0] err);
        token_t t;
        t.kind    = kind;
        t.subtype = sub;
        t.start   = start;
        t.length  = len;
        t.err     = err;
        return t;
    endfunction

    // Character classes and one-character token lookup.
    always_comb begin
        is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
        is_alpha = ((char_code >= 8'h61) && (char_code <= 8'h7A))
                || ((char_code >= 8'h41) && (char_code <= 8'h5A));
        is_ident = is_alpha || is_digit || (char_code == CHAR_UNDERSCORE);
        op_hit  = 1'b0;
        op_idx  = '0;
        del_hit = 1'b0;
        del_idx = '0;
        for (int i = 0; i < NUM_SINGLE; i++) begin
            if (char_code == OP_CHARS[i]) begin
                op_hit = 1'b1;
                op_idx = SUB_BITS'(i);
            end
            if (char_code == DEL_CHARS[i]) begin
                del_hit = 1'b1;
                del_idx = SUB_BITS'(i);
            end
        end
    end

    // Tokens that the pending word or number would give if it ended now.
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (!kw_hit && (len_reg == LENGTH_BITS'(KW_LEN[i]))
                    && (prefix_reg == KW_TEXT[i])) begin
                kw_hit = 1'b1;
                kw_idx = SUB_BITS'(i);
            end
        end
        start16  = START_BITS'(start_reg);
        pos16    = START_BITS'(pos_reg);
        len_grow = (len_reg == '1) ? len_reg : len_reg + LENGTH_BITS'(1);
        word_tok = kw_hit ? make_tok(KIND_KEYWORD, kw_idx, start16, sat_len(len_reg), ERR_NONE)
                          : make_tok(KIND_IDENT, SUB_NONE, start16, sat_len(len_reg), ERR_NONE);
        num_tok  = make_tok(KIND_LITERAL, dot_reg ? SUB_FLOAT : SUB_INT, start16,
                            sat_len(len_reg), ERR_NONE);
    end

    always_comb begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        dot_next    = dot_reg;
        start_next  = start_reg;
        pos_next    = pos_reg + POSITION_BITS'(1);
        lock_next   = lock_reg;
        flush_valid = 1'b0;
        flush_tok   = '0;
        idle_valid  = 1'b0;
        idle_tok    = '0;
        run_idle    = 1'b0;

        if (end_of_text) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                end
                MODE_WORD: begin
                    flush_valid = 1'b1;
                    flush_tok   = word_tok;
                end
                MODE_NUM: begin
                    flush_valid = 1'b1;
                    flush_tok   = num_tok;
                end
                MODE_STR: begin
                    flush_valid = 1'b1;
                    flush_tok   = make_tok(KIND_LITERAL, SUB_STRING, start16,
                                           sat_len(len_reg), ERR_OPEN_STR);
                end
            endcase
            mode_next   = MODE_IDLE;
            len_next    = '0;
            dot_next    = 1'b0;
            prefix_next = '0;
            lock_next   = 1'b0;
            pos_next    = '0;
        end else if (!lock_reg) begin
            unique case (mode_reg)
                MODE_STR: begin
                    len_next = len_grow;
                    if (char_code == CHAR_QUOTE) begin
                        flush_valid = 1'b1;
                        flush_tok   = make_tok(KIND_LITERAL, SUB_STRING, start16,
                                               sat_len(len_grow), ERR_NONE);
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (is_ident) begin
                        if (len_reg < LENGTH_BITS'(PREFIX_CHARS)) begin
                            prefix_next = {prefix_reg[PREFIX_BITS-9:0], char_code};
                        end
                        len_next = len_grow;
                    end else begin
                        flush_valid = 1'b1;
                        flush_tok   = word_tok;
                        mode_next   = MODE_IDLE;
                        run_idle    = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit) begin
                        len_next = len_grow;
                    end else if (char_code == CHAR_DOT) begin
                        if (dot_reg) begin
                            flush_valid = 1'b1;
                            flush_tok   = make_tok(KIND_LITERAL, SUB_FLOAT, start16,
                                                   sat_len(len_reg), ERR_SECOND_DOT);
                            mode_next   = MODE_IDLE;
                            lock_next   = 1'b1;
                        end else begin
                            dot_next = 1'b1;
                            len_next = len_grow;
                        end
                    end else begin
                        flush_valid = 1'b1;
                        flush_tok   = num_tok;
                        mode_next   = MODE_IDLE;
                        run_idle    = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    run_idle = 1'b1;
                end
            endcase

            // The character as seen from idle: start a token, emit a single one or skip it.
            if (run_idle) begin
                priority if (is_digit || is_alpha || (char_code == CHAR_UNDERSCORE)
                             || (char_code == CHAR_QUOTE)) begin
                    start_next  = pos_reg;
                    len_next    = LENGTH_BITS'(1);
                    dot_next    = 1'b0;
                    prefix_next = '0;
                    if (is_digit) begin
                        mode_next = MODE_NUM;
                    end else if (char_code == CHAR_QUOTE) begin
                        mode_next = MODE_STR;
                    end else begin
                        mode_next   = MODE_WORD;
                        prefix_next = PREFIX_BITS'(char_code);
                    end
                end else if (del_hit) begin
                    idle_valid = 1'b1;
                    idle_tok   = make_tok(KIND_DELIM, del_idx, pos16, TLEN_BITS'(1), ERR_NONE);
                end else if (op_hit) begin
                    idle_valid = 1'b1;
                    idle_tok   = make_tok(KIND_OPERATOR, op_idx, pos16, TLEN_BITS'(1), ERR_NONE);
                end else begin
                    // Whitespace and unknown bytes are skipped.
                end
            end
        end

        scan_out.count = {1'b0, flush_valid} + {1'b0, idle_valid};
        scan_out.tok0  = flush_valid ? flush_tok : idle_tok;
        scan_out.tok1  = idle_tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            prefix_reg <= '0;
            len_reg    <= '0;
            dot_reg    <= 1'b0;
            start_reg  <= '0;
            pos_reg    <= '0;
            lock_reg   <= 1'b0;
        end else if (take) begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            dot_reg    <= dot_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            lock_reg   <= lock_next;
        end
    end

    `CSL_ASSERT_IMPLY(a_lock_idle, aclk, aresetn, lock_reg, mode_reg == MODE_IDLE, "error lock outside idle")
    `CSL_ASSERT_IMPLY(a_pending_len, aclk, aresetn, mode_reg != MODE_IDLE, len_reg != '0, "pending token with zero length")
    `CSL_ASSERT_IMPLY(a_pair_order, aclk, aresetn, scan_out.count == 2'd2, (scan_out.tok0.kind != KIND_OPERATOR) && (scan_out.tok0.kind != KIND_DELIM), "single character token placed first")

endmodule

`default_nettype wire

### tb/c_subset_lexer_unit_tb.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_unit_tb
// Self-checking bench for the C subset lexer. Source characters are streamed
// in as well-formed token sequences with random content, mixed with noise
// bytes and overlong tokens. A token scanner inside the bench predicts every
// token, and each output beat is checked field by field.
// ----------------------------------------------------------------------------
module c_subset_lexer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csl_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       eot;
    } char_beat_t;

    typedef struct packed {
        token_t tok;
        logic   last;
    } token_exp_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [S_TUSER_BITS-1:0] s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [M_TUSER_BITS-1:0] m_tuser;
    logic                    m_tlast;

    char_beat_t char_queue[$];
    token_exp_t expected_tokens[$];
    token_exp_t step_toks[$];
    int         fail_count    = 0;
    int         stim_count    = 0;
    int         src_idle_pct  = 0;
    int         sink_idle_pct = 0;
    int         src_gap       = 0;
    int         sink_gap      = 0;

    string kw_names[NUM_KW] = '{"long", "break", "do", "while", "float", "printf"};

    // Scanner state, mirroring the lexer after reset.
    lex_mode_t              lx_mode   = MODE_IDLE;
    logic [PREFIX_BITS-1:0] lx_prefix = '0;
    logic [TLEN_BITS-1:0]   lx_len    = '0;
    logic                   lx_dot    = 1'b0;
    logic [START_BITS-1:0]  lx_start  = '0;
    logic [START_BITS-1:0]  lx_pos    = '0;
    logic                   lx_lock   = 1'b0;

    c_subset_lexer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Token scanner
    // ------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void add_tok(logic [KIND_BITS-1:0] kind, logic [SUB_BITS-1:0] sub,
                                    logic [START_BITS-1:0] start, logic [TLEN_BITS-1:0] len,
                                    logic [ERR_BITS-1:0] err);
        token_exp_t t;
        t.tok.kind    = kind;
        t.tok.subtype = sub;
        t.tok.start   = start;
        t.tok.length  = len;
        t.tok.err     = err;
        t.last        = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void grow_len();
        if (lx_len != TOKEN_LEN_MAX)
            lx_len = lx_len + 1'b1;
    endfunction

    // A word is a keyword only when its length and kept prefix both match.
    function automatic void flush_word();
        bit                  hit;
        logic [SUB_BITS-1:0] kw;
        hit = 1'b0;
        kw  = SUB_NONE;
        for (int i = 0; i < NUM_KW; i++) begin
            if (!hit && lx_len == KW_LEN[i] && lx_prefix == KW_TEXT[i]) begin
                hit = 1'b1;
                kw  = SUB_BITS'(i);
            end
        end
        add_tok(hit ? KIND_KEYWORD : KIND_IDENT, kw, lx_start, lx_len, ERR_NONE);
    endfunction

    function automatic void open_token(lex_mode_t m);
        lx_mode   = m;
        lx_start  = lx_pos;
        lx_len    = TLEN_BITS'(1);
        lx_dot    = 1'b0;
        lx_prefix = '0;
    endfunction

    function automatic void scan_idle(logic [7:0] c);
        if (is_blank(c))
            return;
        if (is_digit(c)) begin
            open_token(MODE_NUM);
        end else if (is_alpha(c) || c == CHAR_UNDERSCORE) begin
            open_token(MODE_WORD);
            lx_prefix = PREFIX_BITS'(c);
        end else if (c == CHAR_QUOTE) begin
            open_token(MODE_STR);
        end else begin
            for (int i = 0; i < NUM_SINGLE; i++) begin
                if (c == DEL_CHARS[i])
                    add_tok(KIND_DELIM, SUB_BITS'(i), lx_pos, TLEN_BITS'(1), ERR_NONE);
                else if (c == OP_CHARS[i])
                    add_tok(KIND_OPERATOR, SUB_BITS'(i), lx_pos, TLEN_BITS'(1), ERR_NONE);
            end
        end
    endfunction

    function automatic void scan_beat(logic [7:0] c, logic eot);
        token_exp_t t;
        step_toks.delete();
        if (eot) begin
            case (lx_mode)
                MODE_WORD: flush_word();
                MODE_NUM:  add_tok(KIND_LITERAL, lx_dot ? SUB_FLOAT : SUB_INT, lx_start, lx_len,
                                   ERR_NONE);
                MODE_STR:  add_tok(KIND_LITERAL, SUB_STRING, lx_start, lx_len, ERR_OPEN_STR);
                default: ;
            endcase
            lx_mode   = MODE_IDLE;
            lx_len    = '0;
            lx_dot    = 1'b0;
            lx_prefix = '0;
            lx_lock   = 1'b0;
            lx_pos    = '0;
        end else begin
            if (!lx_lock) begin
                case (lx_mode)
                    MODE_STR: begin
                        grow_len();
                        if (c == CHAR_QUOTE) begin
                            add_tok(KIND_LITERAL, SUB_STRING, lx_start, lx_len, ERR_NONE);
                            lx_mode = MODE_IDLE;
                        end
                    end
                    MODE_WORD: begin
                        if (is_alpha(c) || is_digit(c) || c == CHAR_UNDERSCORE) begin
                            if (lx_len < PREFIX_CHARS)
                                lx_prefix = {lx_prefix[PREFIX_BITS-9:0], c};
                            grow_len();
                        end else begin
                            flush_word();
                            lx_mode = MODE_IDLE;
                            scan_idle(c);
                        end
                    end
                    MODE_NUM: begin
                        if (is_digit(c)) begin
                            grow_len();
                        end else if (c == CHAR_DOT) begin
                            if (lx_dot) begin
                                add_tok(KIND_LITERAL, SUB_FLOAT, lx_start, lx_len,
                                        ERR_SECOND_DOT);
                                lx_mode = MODE_IDLE;
                                lx_lock = 1'b1;
                            end else begin
                                lx_dot = 1'b1;
                                grow_len();
                            end
                        end else begin
                            add_tok(KIND_LITERAL, lx_dot ? SUB_FLOAT : SUB_INT, lx_start,
                                    lx_len, ERR_NONE);
                            lx_mode = MODE_IDLE;
                            scan_idle(c);
                        end
                    end
                    default: scan_idle(c);
                endcase
            end
            lx_pos = lx_pos + 1'b1;
        end
        for (int i = 0; i < step_toks.size(); i++) begin
            t      = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_chars
        char_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (char_queue.size() > 0 && $urandom_range(0, 99) < src_idle_pct) begin
                src_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (char_queue.size() > 0) begin
                beat = char_queue.pop_front();
                s_tdata  <= beat.code;
                s_tuser  <= beat.eot;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on accepted input beats, checks output beats
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch_tokens
        token_exp_t t;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                scan_beat(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token beat with none outstanding: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    t = expected_tokens.pop_front();
                    check_field("token_kind", t.tok.kind, m_tuser[KIND_BITS-1:0]);
                    check_field("token_subtype", t.tok.subtype, m_tuser[KIND_BITS +: SUB_BITS]);
                    check_field("start_position", t.tok.start, m_tdata[START_BITS-1:0]);
                    check_field("token_length", t.tok.length, m_tdata[START_BITS +: TLEN_BITS]);
                    check_field("error_code", t.tok.err,
                                m_tdata[START_BITS+TLEN_BITS +: ERR_BITS]);
                    check_field("last_in_run", t.last, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_char(logic [7:0] c, logic eot = 1'b0);
        char_beat_t beat;
        beat.code = c;
        beat.eot  = eot;
        char_queue.push_back(beat);
        stim_count++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_eot();
        push_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_word_char(bit lead);
        int unsigned r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'(32'h61 + r);
        if (r < 52)
            return 8'(32'h41 + r - 26);
        if (r == 52)
            return CHAR_UNDERSCORE;
        return 8'(32'h30 + r - 53);
    endfunction

    function automatic logic [7:0] rand_blank();
        int unsigned r;
        r = $urandom_range(0, 6);
        return (r == 6) ? 8'h20 : 8'(9 + (r % 5));
    endfunction

    task automatic push_digits(int n);
        for (int i = 0; i < n; i++)
            push_char(8'(32'h30 + $urandom_range(0, 9)));
    endtask

    // One lexeme of random content, most of them well formed.
    task automatic add_lexeme();
        int unsigned pick;
        int unsigned k;
        int unsigned n;
        logic [7:0]  c;
        pick = $urandom_range(0, 11);
        k    = $urandom_range(0, NUM_KW - 1);
        case (pick)
            0: push_text(kw_names[k]);
            1: begin
                // Near misses: a keyword with a tail, or a keyword cut short.
                if ($urandom_range(0, 1)) begin
                    push_text(kw_names[k]);
                    push_char(rand_word_char(1'b0));
                end else begin
                    push_text(kw_names[k].substr(0, kw_names[k].len() - 2));
                end
            end
            2, 3: begin
                n = $urandom_range(0, 3) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6);
                push_char(rand_word_char(1'b1));
                for (int i = 1; i < n; i++)
                    push_char(rand_word_char(1'b0));
            end
            4: push_digits($urandom_range(1, 6));
            5: begin
                push_digits($urandom_range(1, 3));
                push_char(CHAR_DOT);
                push_digits($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) begin
                    push_char(CHAR_DOT);
                    push_digits($urandom_range(0, 2));
                end
            end
            6: begin
                push_char(CHAR_QUOTE);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    c = ($urandom_range(0, 20) == 0) ? 8'h0A : 8'($urandom_range(32, 126));
                    push_char(c == CHAR_QUOTE ? 8'h78 : c);
                end
                if ($urandom_range(0, 9) != 0)
                    push_char(CHAR_QUOTE);
            end
            7: push_char(OP_CHARS[k]);
            8: push_char(DEL_CHARS[k]);
            9: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_char(rand_blank());
            end
            10: push_char(8'($urandom_range(0, 255)));
            default: push_char($urandom_range(0, 1) ? CHAR_DOT : CHAR_UNDERSCORE);
        endcase
        if ($urandom_range(0, 1))
            push_char(rand_blank());
    endtask

    task automatic add_random_text();
        int unsigned n;
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 16);
            for (int i = 0; i < n; i++)
                push_char(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                add_lexeme();
        end
        push_eot();
    endtask

    task automatic wait_drained();
        while (char_queue.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    int seg_src_pct  [5] = '{25, 0, 10, 45, 0};
    int seg_sink_pct [5] = '{25, 0, 50, 10, 0};

    initial begin
        src_idle_pct  = 20;
        sink_idle_pct = 20;

        // Directed: extreme bytes, keyword ending on a delimiter, second dot
        // with the lock that follows, open string at end, flushes.
        push_char(8'h00);
        push_char(8'hFF);
        push_text("do{1.5.7+x}");
        push_eot();
        push_text("\"a");
        push_eot();
        push_text("q9;7");
        push_eot();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // Overlong word, number and string saturate their length.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        push_char(8'h77);
        for (int i = 0; i < 259; i++)
            push_char(rand_word_char(1'b0));
        push_char(8'h3B);
        push_digits(130);
        push_char(CHAR_DOT);
        push_digits(130);
        push_eot();
        push_char(CHAR_QUOTE);
        for (int i = 0; i < 260; i++)
            push_char(8'(32'h61 + $urandom_range(0, 25)));
        push_char(CHAR_QUOTE);
        push_char(CHAR_QUOTE);
        for (int i = 0; i < 9; i++)
            push_char(8'h62);
        push_eot();
        wait_drained();

        for (int seg = 0; seg < 5; seg++) begin
            src_idle_pct  = seg_src_pct[seg];
            sink_idle_pct = seg_sink_pct[seg];
            stim_count    = 0;
            while (stim_count < 100)
                add_random_text();
            wait_drained();
        end

        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/csl_pkg.sv
hdl/csl_scan.sv
hdl/c_subset_lexer_unit.sv
tb/c_subset_lexer_unit_tb.sv
